>>> rtl/fbdc_pkg.sv
// ---------------------------------------------------------------------------
// Fractional baud divisor calculator: shared package
// Constants, control-word type, microcode program and exponent limit table.
// ---------------------------------------------------------------------------
package fbdc_pkg;

  // Register indexes of the configuration port.
  localparam logic CFG_CLOCK_HZ     = 1'b0;
  localparam logic CFG_DOUBLE_SPEED = 1'b1;

  // Reset value of the clock frequency register.
  localparam logic [31:0] CLOCK_HZ_RESET = 32'd2000000;

  // Range limits: clock / 8 and clock / 4194304, both powers of two.
  localparam int RATE_MAX_SHIFT = 3;
  localparam int RATE_MIN_SHIFT = 22;

  // Exponent search runs over indexes 0..14 (exponent = index - 7).
  localparam logic [3:0] EXP_IDX_LAST = 4'd14;
  localparam logic [3:0] EXP_IDX_ZERO = 4'd7;
  localparam logic [3:0] EXP_IDX_M3   = 4'd4;
  localparam logic [3:0] EXP_OFFSET   = 4'd9;  // index + 9 mod 16 = index - 7

  localparam logic [4:0] DIV_LAST_STEP = 5'd31;

  // Datapath operations.
  localparam logic [2:0] OP_CHECK     = 3'd0;
  localparam logic [2:0] OP_DIV_INIT1 = 3'd1;
  localparam logic [2:0] OP_DIV_STEP  = 3'd2;
  localparam logic [2:0] OP_SEARCH    = 3'd3;
  localparam logic [2:0] OP_PREP     = 3'd4;
  localparam logic [2:0] OP_DIV_INIT2 = 3'd5;
  localparam logic [2:0] OP_FINISH    = 3'd6;
  localparam logic [2:0] OP_REJECT    = 3'd7;

  // Branch conditions.
  localparam logic [1:0] BR_NEVER     = 2'd0;
  localparam logic [1:0] BR_REJ       = 2'd1;
  localparam logic [1:0] BR_DIV_MORE  = 2'd2;
  localparam logic [1:0] BR_SRCH_MORE = 2'd3;

  // Program addresses.
  localparam logic [3:0] PC_CHECK     = 4'd0;
  localparam logic [3:0] PC_DIV_INIT1 = 4'd1;
  localparam logic [3:0] PC_DIV1      = 4'd2;
  localparam logic [3:0] PC_SEARCH    = 4'd3;
  localparam logic [3:0] PC_PREP      = 4'd4;
  localparam logic [3:0] PC_DIV_INIT2 = 4'd5;
  localparam logic [3:0] PC_DIV2      = 4'd6;
  localparam logic [3:0] PC_FINISH    = 4'd7;
  localparam logic [3:0] PC_REJECT    = 4'd8;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] br;
    logic [3:0] tgt;
  } ctrl_word_t;

  // Microcode store: one control word per step.
  function automatic ctrl_word_t ucode_rom(input logic [3:0] pc);
    ctrl_word_t w;
    begin
      unique case (pc)
        PC_CHECK:     w = '{OP_CHECK,     BR_REJ,       PC_REJECT};
        PC_DIV_INIT1: w = '{OP_DIV_INIT1, BR_NEVER,     PC_CHECK};
        PC_DIV1:      w = '{OP_DIV_STEP,  BR_DIV_MORE,  PC_DIV1};
        PC_SEARCH:    w = '{OP_SEARCH,    BR_SRCH_MORE, PC_SEARCH};
        PC_PREP:      w = '{OP_PREP,      BR_NEVER,     PC_CHECK};
        PC_DIV_INIT2: w = '{OP_DIV_INIT2, BR_NEVER,     PC_CHECK};
        PC_DIV2:      w = '{OP_DIV_STEP,  BR_DIV_MORE,  PC_DIV2};
        PC_FINISH:    w = '{OP_FINISH,    BR_NEVER,     PC_CHECK};
        default:      w = '{OP_REJECT,    BR_NEVER,     PC_CHECK};
      endcase
      return w;
    end
  endfunction

  // Limit that the clock-to-rate ratio must stay below for each exponent.
  function automatic logic [21:0] search_limit(input logic [3:0] idx);
    logic [21:0] v;
    begin
      case (idx)
        4'd0:    v = 22'd255;
        4'd1:    v = 22'd511;
        4'd2:    v = 22'd1023;
        4'd3:    v = 22'd2047;
        4'd4:    v = 22'd4095;
        4'd5:    v = 22'd8190;
        4'd6:    v = 22'd16380;
        4'd7:    v = 22'd32760;
        4'd8:    v = 22'd65520;
        4'd9:    v = 22'd131040;
        4'd10:   v = 22'd262080;
        4'd11:   v = 22'd524160;
        4'd12:   v = 22'd1048320;
        4'd13:   v = 22'd2096640;
        default: v = 22'h3FFFFF;
      endcase
      return v;
    end
  endfunction

endpackage

>>> rtl/fractional_baud_divisor_calc_core.sv
// ---------------------------------------------------------------------------
// Fractional baud divisor calculator
// Works out the exponent and 12-bit divisor of a fractional UART baud
// generator for one requested rate.
// ---------------------------------------------------------------------------
// Usage:
// A request is taken on a clock edge where start is high and busy is low;
// in_target_rate is sampled then. Busy stays high while the request is
// worked on. The result shows on out_ok, out_high_byte and out_low_byte
// for exactly one cycle, marked by out_valid; the receiver cannot stall it.
// A new request may be given in the cycle the result is shown.
// A rejected rate goes from the range check straight to the reject
// step. An accepted rate runs two passes of a 32-step restoring divider
// (clock / rate, then the rounded divisor) and a one-compare-per-cycle
// exponent search, all driven by a 9-word microcode program.
// Configuration (clock_hz at index 0, double_speed at index 1) is written
// through cfg_we, cfg_index and cfg_data; the user must write it only
// while busy is low, as the block itself does not enforce this.
// Reset clears busy and the result strobe and loads the register defaults.
// ---------------------------------------------------------------------------
module fractional_baud_divisor_calc_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_target_rate,
  output logic        out_valid,
  output logic        out_ok,
  output logic [7:0]  out_high_byte,
  output logic [7:0]  out_low_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] clock_hz_r;
  logic        double_speed_r;

  logic        busy_r, busy_nxt;
  logic [3:0]  pc_r, pc_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [31:0] num_r, num_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        den_zero_r, den_zero_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r, out_ok_nxt;
  logic [7:0]  out_high_r, out_high_nxt;
  logic [7:0]  out_low_r, out_low_nxt;

  fbdc_pkg::ctrl_word_t cw;

  logic [31:0] rate_top, rate_bottom;
  logic        reject;
  logic [32:0] trial;
  logic        srch_more;
  logic [31:0] num_neg;
  logic [2:0]  num_sh;
  logic [3:0]  den_sh;
  logic [31:0] div_val;
  logic        take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r     <= fbdc_pkg::CLOCK_HZ_RESET;
      double_speed_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fbdc_pkg::CFG_CLOCK_HZ:     clock_hz_r     <= cfg_data;
        fbdc_pkg::CFG_DOUBLE_SPEED: double_speed_r <= cfg_data[0];
        default:                    clock_hz_r     <= clock_hz_r;
      endcase
    end
  end

  // Control word of the current step.
  assign cw = fbdc_pkg::ucode_rom(pc_r);

  // Supported range; halved again without double speed.
  assign rate_top    = (clock_hz_r >> fbdc_pkg::RATE_MAX_SHIFT) >> !double_speed_r;
  assign rate_bottom = (clock_hz_r >> fbdc_pkg::RATE_MIN_SHIFT) >> !double_speed_r;
  assign reject      = (rate_r == 32'd0) || (rate_r > rate_top) || (rate_r < rate_bottom);

  // One restoring division step.
  assign trial = {rem_r, quo_r[31]} - {1'b0, den_r};

  // Exponent search continues while the ratio reaches the current limit.
  assign srch_more = (quo_r >= {10'd0, fbdc_pkg::search_limit(idx_r)})
                     && (idx_r != fbdc_pkg::EXP_IDX_LAST);

  // Operands of the divisor division.
  assign num_neg = clock_hz_r - (rate_r << 3);
  assign num_sh  = 3'(fbdc_pkg::EXP_IDX_M3 - idx_r);
  assign den_sh  = idx_r - fbdc_pkg::EXP_IDX_M3;

  // Rounded quotient, less one for exponents >= 0; zero for a zero divisor.
  assign div_val = den_zero_r ? 32'd0 :
                   (idx_r >= fbdc_pkg::EXP_IDX_ZERO) ? quo_r - 32'd1 : quo_r;

  // Branch decision of the sequencer.
  always_comb begin
    case (cw.br)
      fbdc_pkg::BR_REJ:       take = reject;
      fbdc_pkg::BR_DIV_MORE:  take = (cnt_r != fbdc_pkg::DIV_LAST_STEP);
      fbdc_pkg::BR_SRCH_MORE: take = srch_more;
      default:                take = 1'b0;
    endcase
  end

  // Sequencer and datapath next values.
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    rate_nxt      = rate_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    den_zero_nxt  = den_zero_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_high_nxt  = out_high_r;
    out_low_nxt   = out_low_r;

    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = fbdc_pkg::PC_CHECK;
        rate_nxt = in_target_rate;
      end
    end else begin
      pc_nxt = take ? cw.tgt : pc_r + 4'd1;
      unique case (cw.op)
        fbdc_pkg::OP_CHECK: begin
          if (!double_speed_r) begin
            rate_nxt = rate_r << 1;
          end
        end
        fbdc_pkg::OP_DIV_INIT1: begin
          quo_nxt = clock_hz_r;
          den_nxt = rate_r;
          rem_nxt = 32'd0;
          cnt_nxt = 5'd0;
          idx_nxt = 4'd0;
        end
        fbdc_pkg::OP_DIV_STEP: begin
          cnt_nxt = cnt_r + 5'd1;
          if (!trial[32]) begin
            rem_nxt = trial[31:0];
            quo_nxt = {quo_r[30:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[30:0], quo_r[31]};
            quo_nxt = {quo_r[30:0], 1'b0};
          end
        end
        fbdc_pkg::OP_SEARCH: begin
          if (srch_more) begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        fbdc_pkg::OP_PREP: begin
          if (idx_r <= fbdc_pkg::EXP_IDX_M3) begin
            num_nxt = num_neg << num_sh;
            den_nxt = rate_r;
          end else if (idx_r < fbdc_pkg::EXP_IDX_ZERO) begin
            num_nxt = num_neg;
            den_nxt = rate_r << den_sh;
          end else begin
            num_nxt = clock_hz_r;
            den_nxt = rate_r << den_sh;
          end
        end
        fbdc_pkg::OP_DIV_INIT2: begin
          quo_nxt      = num_r + (den_r >> 1);
          rem_nxt      = 32'd0;
          cnt_nxt      = 5'd0;
          den_zero_nxt = (den_r == 32'd0);
        end
        fbdc_pkg::OP_FINISH: begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_high_nxt  = {idx_r + fbdc_pkg::EXP_OFFSET, div_val[11:8]};
          out_low_nxt   = div_val[7:0];
        end
        fbdc_pkg::OP_REJECT: begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_high_nxt  = 8'd0;
          out_low_nxt   = 8'd0;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= fbdc_pkg::PC_CHECK;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rate_r     <= rate_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    num_r      <= num_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    den_zero_r <= den_zero_nxt;
    out_ok_r   <= out_ok_nxt;
    out_high_r <= out_high_nxt;
    out_low_r  <= out_low_nxt;
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_high_byte = out_high_r;
  assign out_low_byte  = out_low_r;

  // A result appears only as a request finishes.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy_r))
    else $error("result strobe without a request in progress");

  // A rejected request carries zero bytes.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_high_r == 8'd0 && out_low_r == 8'd0))
    else $error("rejected request with non-zero bytes");

  // An accepted request starts the program at its first step.
  a_start_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> (busy_r && pc_r == fbdc_pkg::PC_CHECK))
    else $error("request accepted without starting the program");

  // The exponent index never passes its last value.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && pc_r == fbdc_pkg::PC_PREP) |-> (idx_r <= fbdc_pkg::EXP_IDX_LAST))
    else $error("exponent index out of range");

endmodule
